// ===== rtl/core/prt_pkg.sv =====
// Shared types, register indexes and the sine table generator for the
// polygon rotate/translate unit. Depends on nothing; every other file uses it.
package prt_pkg;

    typedef logic signed [7:0]  corner_coord_t;   // model corner coordinate, whole units
    typedef logic signed [15:0] q12_4_t;          // signed Q12.4 coordinate
    typedef logic [1:0]         corner_idx_t;     // corner number within a request
    typedef logic [2:0]         cfg_index_t;      // configuration register index

    localparam corner_idx_t CORNER_0    = 2'd0;
    localparam corner_idx_t CORNER_1    = 2'd1;
    localparam corner_idx_t LAST_CORNER = 2'd2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    localparam cfg_index_t CFG_CORNER0_X = 3'd0;
    localparam cfg_index_t CFG_CORNER0_Y = 3'd1;
    localparam cfg_index_t CFG_CORNER1_X = 3'd2;
    localparam cfg_index_t CFG_CORNER1_Y = 3'd3;
    localparam cfg_index_t CFG_CORNER2_X = 3'd4;
    localparam cfg_index_t CFG_CORNER2_Y = 3'd5;

    localparam corner_coord_t CORNER0_X_RST = -8'sd4;
    localparam corner_coord_t CORNER0_Y_RST = -8'sd5;
    localparam corner_coord_t CORNER1_X_RST = 8'sd4;
    localparam corner_coord_t CORNER1_Y_RST = -8'sd5;
    localparam corner_coord_t CORNER2_X_RST = 8'sd0;
    localparam corner_coord_t CORNER2_Y_RST = 8'sd5;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Divide a Taylor term by (2k+2)(2k+3); only evaluated while building the table.
    function automatic logic [63:0] taylor_div(input logic [63:0] term, input int k);
        logic [63:0] res;
        case (k)
            0:       res = term / 6;
            1:       res = term / 20;
            2:       res = term / 42;
            3:       res = term / 72;
            4:       res = term / 110;
            5:       res = term / 156;
            6:       res = term / 210;
            7:       res = term / 272;
            8:       res = term / 342;
            9:       res = term / 420;
            10:      res = term / 506;
            11:      res = term / 600;
            12:      res = term / 702;
            13:      res = term / 812;
            14:      res = term / 930;
            default: res = term / 1056;
        endcase
        return res;
    endfunction

    // Quarter-wave sine entry for phase p of 2^(angle_bits-2), in Q1.frac_bits,
    // from a Q2.30 Taylor series rounded half up.
    function automatic logic [63:0] quarter_sine(input int unsigned p,
                                                 input int unsigned angle_bits,
                                                 input int unsigned frac_bits);
        logic [63:0]        q;
        logic [63:0]        one;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        mag;
        logic [63:0]        r;
        logic signed [63:0] acc;
        q   = 64'd1 << (angle_bits - 2);
        one = 64'd1 << frac_bits;
        if (64'(p) == 64'd0) begin
            r = 64'd0;
        end else if (64'(p) >= q) begin
            r = one;
        end else begin
            x    = (HALF_PI_Q30 * 64'(p) + (q >> 1)) >> (angle_bits - 2);
            x2   = (x * x) >> 30;
            term = x;
            acc  = 64'sd0;
            for (int k = 0; k < 16; k++) begin
                if (k[0]) begin
                    acc = acc - $signed(term);
                end else begin
                    acc = acc + $signed(term);
                end
                term = (term * x2) >> 30;
                term = taylor_div(term, k);
            end
            mag = (acc < 64'sd0) ? 64'd0 : $unsigned(acc);
            r   = (mag + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
            if (r > one) begin
                r = one;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/polygon_rotate_translate_unit.sv =====
// Top level of the polygon rotate/translate unit: config registers and pipeline.
// Depends on prt_pkg, prt_trig, prt_mac and prt_round.
//
// Usage:
//   A request beat on the s_ channel carries a binary angle (65536 = full turn)
//   and a center in signed Q12.4. For each request the m_ channel returns
//   three vertex beats, corners 0, 1, 2 in order; tlast marks corner 2.
//   Corners are 8-bit whole-unit coordinates held in six config registers,
//   written through cfg_we/cfg_index/cfg_wdata while the block is idle.
//   Pipeline: input register, trig register (sine/cosine lookup), product
//   register (one corner per cycle unless the receiver stalls), result register.
//   The trig register keeps a request until its last corner moves on and only
//   then takes the next, as the single product and rounding path serves one
//   corner per cycle when the receiver never stalls.
//   Reset (synchronous, aresetn low) empties every stage and restores the
//   default triangle. When the receiver holds m_tready low, the result
//   register holds its beat, the stages behind it fill, and s_tready drops
//   once the input register has nowhere to go.
module polygon_rotate_translate_unit #(
    parameter int ANGLE_BITS     = 10,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  prt_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_wdata,
    // request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,   // [15:0] heading, [31:16] center_x, [47:32] center_y
    // vertex channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [15:0] vertex_x, [31:16] vertex_y
    output logic [2:0]          m_tuser,   // [1:0] vertex_index, [2] clipped
    output logic                m_tlast
);

    localparam int CW   = TRIG_FRAC_BITS + 2;
    localparam int SUMW = TRIG_FRAC_BITS + 11;

    // corner registers
    prt_pkg::corner_coord_t corner_x_reg [3];
    prt_pkg::corner_coord_t corner_y_reg [3];

    // input stage
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [15:0]            heading_reg;
    prt_pkg::q12_4_t        in_cx_reg;
    prt_pkg::q12_4_t        in_cy_reg;

    // trig stage
    logic                   trig_valid_reg;
    logic                   trig_valid_next;
    logic signed [CW-1:0]   sin_reg;
    logic signed [CW-1:0]   cos_reg;
    prt_pkg::q12_4_t        trig_cx_reg;
    prt_pkg::q12_4_t        trig_cy_reg;
    prt_pkg::corner_idx_t   corner_reg;
    prt_pkg::corner_idx_t   corner_next;

    // product stage
    logic                   mac_valid_reg;
    logic                   mac_valid_next;
    logic signed [SUMW-1:0] sum_x_reg;
    logic signed [SUMW-1:0] sum_y_reg;
    prt_pkg::q12_4_t        mac_cx_reg;
    prt_pkg::q12_4_t        mac_cy_reg;
    prt_pkg::corner_idx_t   mac_corner_reg;

    // result stage
    logic                   out_valid_reg;
    logic                   out_valid_next;
    prt_pkg::q12_4_t        vx_reg;
    prt_pkg::q12_4_t        vy_reg;
    prt_pkg::corner_idx_t   out_corner_reg;
    logic                   clip_reg;

    // handshake between stages
    logic                   in_load;
    logic                   trig_load;
    logic                   trig_adv;
    logic                   trig_done;
    logic                   mac_ready;
    logic                   out_ready;
    logic                   out_load;

    // datapath wires
    logic signed [CW-1:0]   sin_val;
    logic signed [CW-1:0]   cos_val;
    prt_pkg::corner_coord_t sel_x;
    prt_pkg::corner_coord_t sel_y;
    logic signed [SUMW-1:0] sum_x;
    logic signed [SUMW-1:0] sum_y;
    prt_pkg::q12_4_t        vertex_x;
    prt_pkg::q12_4_t        vertex_y;
    logic                   clipped;

    // ------------------------------------------------------------------
    // Configuration: write the addressed corner coordinate, drop unknown
    // indexes.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_x_reg[0] <= prt_pkg::CORNER0_X_RST;
            corner_y_reg[0] <= prt_pkg::CORNER0_Y_RST;
            corner_x_reg[1] <= prt_pkg::CORNER1_X_RST;
            corner_y_reg[1] <= prt_pkg::CORNER1_Y_RST;
            corner_x_reg[2] <= prt_pkg::CORNER2_X_RST;
            corner_y_reg[2] <= prt_pkg::CORNER2_Y_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                prt_pkg::CFG_CORNER0_X: corner_x_reg[0] <= cfg_wdata;
                prt_pkg::CFG_CORNER0_Y: corner_y_reg[0] <= cfg_wdata;
                prt_pkg::CFG_CORNER1_X: corner_x_reg[1] <= cfg_wdata;
                prt_pkg::CFG_CORNER1_Y: corner_y_reg[1] <= cfg_wdata;
                prt_pkg::CFG_CORNER2_X: corner_x_reg[2] <= cfg_wdata;
                prt_pkg::CFG_CORNER2_Y: corner_y_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. Each stage advances when the one ahead is empty or
    // moving; the trig stage holds a request until its three corners have moved on.
    // ------------------------------------------------------------------
    assign out_ready = !out_valid_reg || m_tready;
    assign out_load  = mac_valid_reg && out_ready;
    assign mac_ready = !mac_valid_reg || out_ready;
    assign trig_adv  = trig_valid_reg && mac_ready;
    assign trig_done = trig_adv && (corner_reg == prt_pkg::LAST_CORNER);
    assign trig_load = in_valid_reg && (!trig_valid_reg || trig_done);
    assign s_tready  = !in_valid_reg || trig_load;
    assign in_load   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next   = in_load ? 1'b1 : (trig_load ? 1'b0 : in_valid_reg);
        trig_valid_next = trig_load ? 1'b1 : (trig_done ? 1'b0 : trig_valid_reg);
        mac_valid_next  = trig_adv ? 1'b1 : (out_ready ? 1'b0 : mac_valid_reg);
        out_valid_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        if (trig_load) begin
            corner_next = prt_pkg::CORNER_0;
        end else if (trig_adv) begin
            corner_next = corner_reg + 2'd1;
        end else begin
            corner_next = corner_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            trig_valid_reg <= 1'b0;
            mac_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            corner_reg     <= prt_pkg::CORNER_0;
        end else begin
            in_valid_reg   <= in_valid_next;
            trig_valid_reg <= trig_valid_next;
            mac_valid_reg  <= mac_valid_next;
            out_valid_reg  <= out_valid_next;
            corner_reg     <= corner_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: no reset, loaded with their stage's valid.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_load) begin
            heading_reg <= s_tdata[15:0];
            in_cx_reg   <= s_tdata[31:16];
            in_cy_reg   <= s_tdata[47:32];
        end
        if (trig_load) begin
            sin_reg     <= sin_val;
            cos_reg     <= cos_val;
            trig_cx_reg <= in_cx_reg;
            trig_cy_reg <= in_cy_reg;
        end
        if (trig_adv) begin
            sum_x_reg      <= sum_x;
            sum_y_reg      <= sum_y;
            mac_cx_reg     <= trig_cx_reg;
            mac_cy_reg     <= trig_cy_reg;
            mac_corner_reg <= corner_reg;
        end
        if (out_load) begin
            vx_reg         <= vertex_x;
            vy_reg         <= vertex_y;
            out_corner_reg <= mac_corner_reg;
            clip_reg       <= clipped;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    prt_trig #(
        .ANGLE_BITS     (ANGLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_trig (
        .heading (heading_reg),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // pick the corner the trig stage is working on this cycle
    always_comb begin
        case (corner_reg)
            prt_pkg::CORNER_0: begin
                sel_x = corner_x_reg[0];
                sel_y = corner_y_reg[0];
            end
            prt_pkg::CORNER_1: begin
                sel_x = corner_x_reg[1];
                sel_y = corner_y_reg[1];
            end
            default: begin
                sel_x = corner_x_reg[2];
                sel_y = corner_y_reg[2];
            end
        endcase
    end

    prt_mac #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_mac (
        .corner_x (sel_x),
        .corner_y (sel_y),
        .sin_val  (sin_reg),
        .cos_val  (cos_reg),
        .sum_x    (sum_x),
        .sum_y    (sum_y)
    );

    prt_round #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_round (
        .sum_x    (sum_x_reg),
        .sum_y    (sum_y_reg),
        .center_x (mac_cx_reg),
        .center_y (mac_cy_reg),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y),
        .clipped  (clipped)
    );

    // result beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {vy_reg, vx_reg};
    assign m_tuser  = {clip_reg, out_corner_reg};
    assign m_tlast  = (out_corner_reg == prt_pkg::LAST_CORNER);

endmodule

// ===== rtl/core/prt_trig.sv =====
// Sine/cosine lookup from a binary angle through a quarter-wave constant table.
// Depends on prt_pkg (table generator, quadrant codes).
module prt_trig #(
    parameter int ANGLE_BITS     = 10,
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic [15:0]                   heading,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

    localparam int PW = ANGLE_BITS - 2;
    localparam int QN = 1 << PW;
    localparam int TW = TRIG_FRAC_BITS + 1;
    localparam logic [TW-1:0] ONE = {1'b1, {TRIG_FRAC_BITS{1'b0}}};

    logic [TW-1:0]              sine_rom [QN];
    logic [ANGLE_BITS-1:0]      angle_idx;
    logic [1:0]                 quadrant;
    logic [PW-1:0]              phase;
    logic [PW-1:0]              phase_neg;
    logic [TW-1:0]              t_p;
    logic [TW-1:0]              t_c;
    logic signed [TW:0]         pos_p;
    logic signed [TW:0]         pos_c;

    for (genvar g = 0; g < QN; g++) begin : g_rom
        assign sine_rom[g] = TW'(prt_pkg::quarter_sine(g, ANGLE_BITS, TRIG_FRAC_BITS));
    end

    assign angle_idx = heading[15 -: ANGLE_BITS];
    assign quadrant  = angle_idx[ANGLE_BITS-1 -: 2];
    assign phase     = angle_idx[PW-1:0];
    assign phase_neg = ~phase + PW'(1);

    // cos of phase is the sine of the complementary phase; a full quarter is 1.0
    assign t_p   = sine_rom[phase];
    assign t_c   = (phase == '0) ? ONE : sine_rom[phase_neg];
    assign pos_p = $signed({1'b0, t_p});
    assign pos_c = $signed({1'b0, t_c});

    always_comb begin
        case (quadrant)
            prt_pkg::QUAD_0: begin
                sin_val = pos_p;
                cos_val = pos_c;
            end
            prt_pkg::QUAD_1: begin
                sin_val = pos_c;
                cos_val = -pos_p;
            end
            prt_pkg::QUAD_2: begin
                sin_val = -pos_p;
                cos_val = -pos_c;
            end
            default: begin
                sin_val = -pos_c;
                cos_val = pos_p;
            end
        endcase
    end

endmodule

// ===== rtl/core/prt_mac.sv =====
// Rotation products for one corner: x*cos - y*sin and x*sin + y*cos.
// Depends on prt_pkg (corner coordinate type).
module prt_mac #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  prt_pkg::corner_coord_t            corner_x,
    input  prt_pkg::corner_coord_t            corner_y,
    input  logic signed [TRIG_FRAC_BITS+1:0]  sin_val,
    input  logic signed [TRIG_FRAC_BITS+1:0]  cos_val,
    output logic signed [TRIG_FRAC_BITS+10:0] sum_x,
    output logic signed [TRIG_FRAC_BITS+10:0] sum_y
);

    localparam int PW   = TRIG_FRAC_BITS + 10;
    localparam int SUMW = PW + 1;

    logic signed [PW-1:0] xc;
    logic signed [PW-1:0] ys;
    logic signed [PW-1:0] xs;
    logic signed [PW-1:0] yc;

    assign xc = PW'(corner_x) * PW'(cos_val);
    assign ys = PW'(corner_y) * PW'(sin_val);
    assign xs = PW'(corner_x) * PW'(sin_val);
    assign yc = PW'(corner_y) * PW'(cos_val);

    assign sum_x = SUMW'(xc) - SUMW'(ys);
    assign sum_y = SUMW'(xs) + SUMW'(yc);

endmodule

// ===== rtl/core/prt_round.sv =====
// Round rotated sums to Q12.4 (half up), add the center, saturate to 16 bits.
// Depends on prt_pkg (Q12.4 coordinate type).
module prt_round #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic signed [TRIG_FRAC_BITS+10:0] sum_x,
    input  logic signed [TRIG_FRAC_BITS+10:0] sum_y,
    input  prt_pkg::q12_4_t                   center_x,
    input  prt_pkg::q12_4_t                   center_y,
    output prt_pkg::q12_4_t                   vertex_x,
    output prt_pkg::q12_4_t                   vertex_y,
    output logic                              clipped
);

    localparam int SUMW = TRIG_FRAC_BITS + 11;
    localparam int SH   = TRIG_FRAC_BITS - 4;
    localparam int RW   = SUMW - SH;
    localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (SH - 1);

    logic signed [SUMW-1:0] bx;
    logic signed [SUMW-1:0] by;
    logic signed [RW-1:0]   rx;
    logic signed [RW-1:0]   ry;
    logic signed [16:0]     tx;
    logic signed [16:0]     ty;
    logic                   clip_x;
    logic                   clip_y;

    // arithmetic shift floors, so adding half first rounds half up
    assign bx = sum_x + HALF;
    assign by = sum_y + HALF;
    assign rx = RW'(bx >>> SH);
    assign ry = RW'(by >>> SH);

    assign tx = 17'(rx) + 17'(center_x);
    assign ty = 17'(ry) + 17'(center_y);

    // overflow when the two top bits disagree; clamp toward the sign
    assign clip_x = tx[16] ^ tx[15];
    assign clip_y = ty[16] ^ ty[15];

    assign vertex_x = clip_x ? (tx[16] ? 16'sh8000 : 16'sh7FFF) : tx[15:0];
    assign vertex_y = clip_y ? (ty[16] ? 16'sh8000 : 16'sh7FFF) : ty[15:0];
    assign clipped  = clip_x | clip_y;

endmodule

// ===== rtl/core/prt_check.sv =====
// Port-level checks for the polygon rotate/translate unit, bound to the top.
// Depends on prt_pkg (corner codes) and polygon_rotate_translate_unit.
module prt_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled vertex beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("vertex beat changed while stalled");

    // tlast marks exactly the third corner
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] == prt_pkg::LAST_CORNER)))
        else $error("tlast does not match corner index");

    // corner index never leaves the triangle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == prt_pkg::CORNER_0 || m_tuser[1:0] == prt_pkg::CORNER_1
                      || m_tuser[1:0] == prt_pkg::LAST_CORNER))
        else $error("corner index out of range");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("vertex valid after reset");

endmodule

bind polygon_rotate_translate_unit prt_check u_prt_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/polygon_rotate_translate_unit_tb.sv =====
// Self-checking bench for polygon_rotate_translate_unit: rotates and places the
// stored triangle in a local predictor and checks every vertex beat against it.
// Depends on prt_pkg and the unit's RTL only.
module polygon_rotate_translate_unit_tb;

    localparam int ANGLE_BITS     = 10;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int QTR            = 1 << (ANGLE_BITS - 2);
    localparam int ROUND_SHIFT    = TRIG_FRAC_BITS - 4;
    localparam longint unsigned HALF_TURN_Q30 = 64'd1686629713;   // pi/2 in Q2.30
    localparam int CYCLE_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 55;

    // Register indexes past the last corner; writes there must change nothing.
    localparam prt_pkg::cfg_index_t CFG_SPARE_6 = 3'd6;
    localparam prt_pkg::cfg_index_t CFG_SPARE_7 = 3'd7;

    typedef enum int {TRI_MAX, TRI_MIN, TRI_EXTREME, TRI_RANDOM} triangle_mode_t;

    typedef struct packed {
        logic [15:0]     heading;
        prt_pkg::q12_4_t center_x;
        prt_pkg::q12_4_t center_y;
    } request_t;

    typedef struct packed {
        prt_pkg::q12_4_t      x;
        prt_pkg::q12_4_t      y;
        prt_pkg::corner_idx_t index;
        logic                 last;
        logic                 clipped;
    } vertex_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    prt_pkg::cfg_index_t cfg_index = prt_pkg::CFG_CORNER0_X;
    logic [7:0]          cfg_wdata = 8'd0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata   = 48'd0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;   // [15:0] vertex_x, [31:16] vertex_y
    logic [2:0]          m_tuser;   // [1:0] vertex_index, [2] clipped
    logic                m_tlast;

    // Queue of requests still to be sent, and vertices the unit still owes.
    request_t request_backlog[$];
    vertex_t  vertex_due[$];

    // Local copy of the triangle registers and the quarter-wave sine table.
    prt_pkg::corner_coord_t corner_x[3] = '{prt_pkg::CORNER0_X_RST, prt_pkg::CORNER1_X_RST,
                                            prt_pkg::CORNER2_X_RST};
    prt_pkg::corner_coord_t corner_y[3] = '{prt_pkg::CORNER0_Y_RST, prt_pkg::CORNER1_Y_RST,
                                            prt_pkg::CORNER2_Y_RST};
    prt_pkg::corner_idx_t   corner_tag[3] = '{prt_pkg::CORNER_0, prt_pkg::CORNER_1,
                                              prt_pkg::LAST_CORNER};
    prt_pkg::cfg_index_t    corner_regs[6] = '{prt_pkg::CFG_CORNER0_X, prt_pkg::CFG_CORNER0_Y,
                                               prt_pkg::CFG_CORNER1_X, prt_pkg::CFG_CORNER1_Y,
                                               prt_pkg::CFG_CORNER2_X, prt_pkg::CFG_CORNER2_Y};
    longint        quarter_wave[0:QTR];

    int fail_count     = 0;
    int requests_sent  = 0;
    int vertices_seen  = 0;
    int clipped_seen   = 0;
    int settings_used  = 1;
    int cycle_count    = 0;
    int gap_left       = 0;
    int burst_left     = 1;
    int stall_mode     = 0;
    int stall_hold     = 0;

    polygon_rotate_translate_unit #(
        .ANGLE_BITS    (ANGLE_BITS),
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [15:0] heading, [31:16] center_x, [47:32] center_y
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // [15:0] vertex_x, [31:16] vertex_y
        .m_tuser  (m_tuser),     // [1:0] vertex_index, [2] clipped
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Sine of (pi/2 * p/QTR) in Q1.14: Q2.30 Taylor series, rounded half up.
    function automatic longint taylor_sine(input int p);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint          acc;
        if (p == 0) begin
            return 0;
        end
        if (p >= QTR) begin
            return longint'(1) << TRIG_FRAC_BITS;
        end
        x    = (HALF_TURN_Q30 * longint'(p) + longint'(QTR / 2)) / longint'(QTR);
        x2   = (x * x) >> 30;
        term = x;
        acc  = 0;
        for (int k = 0; k < 16 && term != 0; k++) begin
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
            term = (term * x2) >> 30;
            term = term / longint'((2 * k + 2) * (2 * k + 3));
        end
        if (acc < 0) begin
            acc = 0;
        end
        r = (longint'(acc) + (longint'(1) << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        if (r > (longint'(1) << TRIG_FRAC_BITS)) begin
            r = longint'(1) << TRIG_FRAC_BITS;
        end
        return longint'(r);
    endfunction

    initial begin
        for (int p = 0; p <= QTR; p++) begin
            quarter_wave[p] = taylor_sine(p);
        end
    end

    // Round a Q.14 sum once to Q.4 (half up), add the center, then saturate.
    function automatic longint place_coord(input longint sum, input prt_pkg::q12_4_t center,
                                           inout logic clip);
        longint v;
        v = ((sum + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT) + longint'(center);
        if (v > 32767) begin
            clip = 1'b1;
            v    = 32767;
        end else if (v < -32768) begin
            clip = 1'b1;
            v    = -32768;
        end
        return v;
    endfunction

    // Work out the three vertices one request owes and queue them in order.
    task automatic rotate_and_place(input request_t req);
        int      angle_idx;
        int      phase;
        longint  tp;
        longint  tc;
        longint  sin_v;
        longint  cos_v;
        longint  px;
        longint  py;
        longint  rx;
        longint  ry;
        logic    clip;
        vertex_t v;
        angle_idx = int'(req.heading) >> (16 - ANGLE_BITS);
        phase     = angle_idx & (QTR - 1);
        tp        = quarter_wave[phase];
        tc        = quarter_wave[QTR - phase];
        case (2'(angle_idx >> (ANGLE_BITS - 2)))
            prt_pkg::QUAD_0: begin
                sin_v = tp;
                cos_v = tc;
            end
            prt_pkg::QUAD_1: begin
                sin_v = tc;
                cos_v = -tp;
            end
            prt_pkg::QUAD_2: begin
                sin_v = -tp;
                cos_v = -tc;
            end
            default: begin
                sin_v = -tc;
                cos_v = tp;
            end
        endcase
        for (int k = 0; k < 3; k++) begin
            clip      = 1'b0;
            px        = longint'(corner_x[k]);
            py        = longint'(corner_y[k]);
            rx        = place_coord(px * cos_v - py * sin_v, req.center_x, clip);
            ry        = place_coord(px * sin_v + py * cos_v, req.center_y, clip);
            v.x       = rx[15:0];
            v.y       = ry[15:0];
            v.index   = corner_tag[k];
            v.last    = (corner_tag[k] == prt_pkg::LAST_CORNER);
            v.clipped = clip;
            vertex_due.insert(vertex_due.size(), v);
        end
    endtask

    // Request driver: bursts of random length, random gaps between them.
    // Hold tvalid and tdata on a stalled beat; pick the next beat otherwise.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            gap_left   = 0;
            burst_left = 1;
        end else begin
            if (s_tvalid && s_tready) begin
                rotate_and_place(request_backlog[0]);
                request_backlog.pop_front();
                requests_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    // Long bursts with no gap leave stretches at full rate.
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            if (s_tvalid && !s_tready) begin
                // hold the current beat
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {request_backlog[0].center_y, request_backlog[0].center_x,
                             request_backlog[0].heading};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Vertex monitor: check each beat against the oldest owed vertex, and
    // drive tready from a stall pattern that switches mode now and then.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b1;
        end else begin
            if (m_tvalid && m_tready) begin
                vertices_seen++;
                if (vertex_due.size() == 0) begin
                    $error("unexpected vertex beat: x %0d y %0d index %0d",
                           $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser[1:0]);
                    fail_count++;
                end else begin
                    if (m_tdata[15:0] !== vertex_due[0].x) begin
                        $error("vertex_x mismatch: expected %0d, got %0d",
                               vertex_due[0].x, $signed(m_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_tdata[31:16] !== vertex_due[0].y) begin
                        $error("vertex_y mismatch: expected %0d, got %0d",
                               vertex_due[0].y, $signed(m_tdata[31:16]));
                        fail_count++;
                    end
                    if (m_tuser[1:0] !== vertex_due[0].index) begin
                        $error("vertex_index mismatch: expected %0d, got %0d",
                               vertex_due[0].index, m_tuser[1:0]);
                        fail_count++;
                    end
                    if (m_tlast !== vertex_due[0].last) begin
                        $error("last_vertex mismatch: expected %0d, got %0d",
                               vertex_due[0].last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser[2] !== vertex_due[0].clipped) begin
                        $error("clipped mismatch: expected %0d, got %0d",
                               vertex_due[0].clipped, m_tuser[2]);
                        fail_count++;
                    end
                    if (vertex_due[0].clipped) begin
                        clipped_seen++;
                    end
                    vertex_due.pop_front();
                end
            end
            if (stall_hold == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_hold = $urandom_range(50, 300);
            end else begin
                stall_hold--;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ((cycle_count % 7) < 4);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: end the run if the traffic never drains.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Queue one request for the driver.
    task automatic send_request(input logic [15:0] heading, input prt_pkg::q12_4_t cx,
                                input prt_pkg::q12_4_t cy);
        request_t req;
        req.heading  = heading;
        req.center_x = cx;
        req.center_y = cy;
        request_backlog.insert(request_backlog.size(), req);
    endtask

    // Wait until every queued request is sent and every owed vertex has arrived, then settle.
    task automatic wait_idle();
        while (request_backlog.size() != 0 || vertex_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // Write one register at a clock edge and mirror it in the local copy.
    task automatic write_reg(input prt_pkg::cfg_index_t idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            prt_pkg::CFG_CORNER0_X: corner_x[0] = prt_pkg::corner_coord_t'(val);
            prt_pkg::CFG_CORNER0_Y: corner_y[0] = prt_pkg::corner_coord_t'(val);
            prt_pkg::CFG_CORNER1_X: corner_x[1] = prt_pkg::corner_coord_t'(val);
            prt_pkg::CFG_CORNER1_Y: corner_y[1] = prt_pkg::corner_coord_t'(val);
            prt_pkg::CFG_CORNER2_X: corner_x[2] = prt_pkg::corner_coord_t'(val);
            prt_pkg::CFG_CORNER2_Y: corner_y[2] = prt_pkg::corner_coord_t'(val);
            default: ;
        endcase
    endtask

    // Load a new triangle, poke both spare indexes, then release the port.
    task automatic load_triangle(input triangle_mode_t mode);
        logic [7:0] val;
        for (int i = 0; i < 6; i++) begin
            case (mode)
                TRI_MAX: val = 8'h7F;
                TRI_MIN: val = 8'h80;
                TRI_EXTREME: begin
                    case ($urandom_range(0, 2))
                        0:       val = 8'h80;
                        1:       val = 8'h7F;
                        default: val = 8'($urandom);
                    endcase
                end
                default: val = 8'($urandom);
            endcase
            write_reg(corner_regs[i], val);
        end
        write_reg(CFG_SPARE_6, 8'($urandom));
        write_reg(CFG_SPARE_7, 8'($urandom));
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge aclk);
    endtask

    initial begin : sequencer
        request_t req;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset triangle: quadrant edges, first and last table steps, clipping.
        send_request(16'h0000, 16'sd0, 16'sd0);
        send_request(16'h4000, 16'sd0, 16'sd0);
        send_request(16'h8000, 16'sd0, 16'sd0);
        send_request(16'hC000, 16'sd0, 16'sd0);
        send_request(16'hFFFF, 16'sd0, 16'sd0);
        send_request(16'h003F, 16'sd16, -16'sd16);    // below the first angle step
        send_request(16'h0040, 16'sd0, 16'sd0);
        send_request(16'h3FC0, 16'sd0, 16'sd0);       // last entry before quarter turn
        send_request(16'h2000, 16'sd100, -16'sd100);
        send_request(16'h0000, 16'sd32767, 16'sd32767);
        send_request(16'h8000, -16'sd32768, -16'sd32768);
        send_request(16'h6000, 16'sd32767, -16'sd32768);
        send_request(16'hA000, -16'sd1, 16'sd1);
        wait_idle();

        load_triangle(TRI_MAX);
        send_request(16'h0000, 16'sd32767, 16'sd32767);
        send_request(16'h2000, 16'sd0, 16'sd0);
        send_request(16'h6000, -16'sd32768, 16'sd32767);
        send_request(16'hE000, 16'sd1234, -16'sd4321);
        wait_idle();

        load_triangle(TRI_MIN);
        send_request(16'h0000, -16'sd32768, -16'sd32768);
        send_request(16'h4000, 16'sd32767, 16'sd0);
        send_request(16'h9FFF, 16'sd0, 16'sd0);
        send_request(16'hDFC0, -16'sd20000, 16'sd20000);
        wait_idle();

        // Random part: new triangle per phase, mostly random angles and centers,
        // with a share near quadrant edges and near the saturation limits.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_triangle((ph % 4 == 0) ? TRI_EXTREME : TRI_RANDOM);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                req.heading = 16'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    req.heading = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 127) - 64);
                end
                req.center_x = 16'($urandom);
                req.center_y = 16'($urandom);
                if ($urandom_range(0, 2) == 0) begin
                    req.center_x = $urandom_range(0, 1) ? 16'(32767 - $urandom_range(0, 4095))
                                                        : 16'(-32768 + $urandom_range(0, 4095));
                end
                if ($urandom_range(0, 2) == 0) begin
                    req.center_y = $urandom_range(0, 1) ? 16'(32767 - $urandom_range(0, 4095))
                                                        : 16'(-32768 + $urandom_range(0, 4095));
                end
                request_backlog.insert(request_backlog.size(), req);
            end
            wait_idle();
        end

        // Catch any stray beat that trails the last owed vertex.
        repeat (20) @(posedge aclk);
        if (vertex_due.size() != 0) begin
            $error("%0d vertices never arrived", vertex_due.size());
            fail_count++;
        end
        $display("Sent %0d requests over %0d triangle settings; checked %0d vertex beats",
                 requests_sent, settings_used, vertices_seen);
        $display("Saturated vertices seen: %0d; mismatches: %0d", clipped_seen, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
